>>> design/assert_macros.svh
// Assertion macros used by the checker file of the collision unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DPC_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DPC_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/dpc_pkg.sv
// Types and constants of the disc pair collision unit.
package dpc_pkg;

    localparam int QUO_W      = 19;   // impulse magnitude is below 2^19
    localparam int DEN_W      = 50;   // (mass sum) * |d|^2
    localparam int NUM_W      = 66;   // 2 * mass * |d component| * |dv.d|
    localparam int DIV_STAGES = QUO_W;
    localparam int LANES      = 4;

    // Lane order of the four velocity components.
    localparam int LANE_AX = 0;
    localparam int LANE_AY = 1;
    localparam int LANE_BX = 2;
    localparam int LANE_BY = 3;

    localparam logic signed [20:0] VEL_MAX = 21'sd32767;
    localparam logic signed [20:0] VEL_MIN = -21'sd32768;

    typedef struct packed {
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_vx;
        logic signed [15:0] first_vy;
        logic [15:0]        first_mass;
        logic [14:0]        first_radius;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_vx;
        logic signed [15:0] second_vy;
        logic [15:0]        second_mass;
        logic [14:0]        second_radius;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] new_first_vx;
        logic signed [15:0] new_first_vy;
        logic signed [15:0] new_second_vx;
        logic signed [15:0] new_second_vy;
        logic               saturated;
    } t_out;

    // Sideband that rides along with the division.
    typedef struct packed {
        logic                    hit;
        logic                    act;
        logic [LANES-1:0]        neg;
        logic [LANES-1:0][15:0]  vel;
    } t_side;

endpackage

>>> design/dpc_front.sv
// Geometry front end: differences, products, hit test, numerators and divisor.
module dpc_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  dpc_pkg::t_in                             i_data,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [dpc_pkg::LANES-1:0][dpc_pkg::NUM_W-1:0] o_num,
    output logic [dpc_pkg::DEN_W-1:0]                o_den,
    output dpc_pkg::t_side                           o_side
);

    logic [5:0] r_v;
    logic [5:0] en;

    assign en[5] = !r_v[5] || i_ready;
    assign en[4] = !r_v[4] || en[5];
    assign en[3] = !r_v[3] || en[4];
    assign en[2] = !r_v[2] || en[3];
    assign en[1] = !r_v[1] || en[2];
    assign en[0] = !r_v[0] || en[1];
    assign o_ready = en[0];
    assign o_valid = r_v[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
            if (en[4]) r_v[4] <= r_v[3];
            if (en[5]) r_v[5] <= r_v[4];
        end
    end

    // stage 1: differences and sums
    logic signed [16:0] r1_dx, r1_dy, r1_dvx, r1_dvy;
    logic [15:0]        r1_rs;
    logic [16:0]        r1_msum;
    logic [15:0]        r1_am, r1_bm;
    logic [3:0][15:0]   r1_vel;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_dx   <= {i_data.second_x[15], i_data.second_x}
                     - {i_data.first_x[15], i_data.first_x};
            r1_dy   <= {i_data.second_y[15], i_data.second_y}
                     - {i_data.first_y[15], i_data.first_y};
            r1_dvx  <= {i_data.second_vx[15], i_data.second_vx}
                     - {i_data.first_vx[15], i_data.first_vx};
            r1_dvy  <= {i_data.second_vy[15], i_data.second_vy}
                     - {i_data.first_vy[15], i_data.first_vy};
            r1_rs   <= {1'b0, i_data.first_radius} + {1'b0, i_data.second_radius};
            r1_msum <= {1'b0, i_data.first_mass} + {1'b0, i_data.second_mass};
            r1_am   <= i_data.first_mass;
            r1_bm   <= i_data.second_mass;
            r1_vel[dpc_pkg::LANE_AX] <= i_data.first_vx;
            r1_vel[dpc_pkg::LANE_AY] <= i_data.first_vy;
            r1_vel[dpc_pkg::LANE_BX] <= i_data.second_vx;
            r1_vel[dpc_pkg::LANE_BY] <= i_data.second_vy;
        end
    end

    // stage 2: squares and dot terms
    logic signed [33:0] p_sqx, p_sqy, p_dpx, p_dpy;
    logic signed [16:0] m_dx, m_dy;
    logic [31:0]        p_rsq;

    always_comb begin
        p_sqx = r1_dx * r1_dx;
        p_sqy = r1_dy * r1_dy;
        p_dpx = r1_dvx * r1_dx;
        p_dpy = r1_dvy * r1_dy;
        p_rsq = r1_rs * r1_rs;
        m_dx  = r1_dx[16] ? -r1_dx : r1_dx;
        m_dy  = r1_dy[16] ? -r1_dy : r1_dy;
    end

    logic [31:0]        r2_sqx, r2_sqy, r2_rsq;
    logic signed [32:0] r2_dpx, r2_dpy;
    logic [15:0]        r2_adx, r2_ady;
    logic               r2_sdx, r2_sdy;
    logic [16:0]        r2_msum;
    logic [15:0]        r2_am, r2_bm;
    logic [3:0][15:0]   r2_vel;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_sqx  <= p_sqx[31:0];
            r2_sqy  <= p_sqy[31:0];
            r2_rsq  <= p_rsq;
            r2_dpx  <= p_dpx[32:0];
            r2_dpy  <= p_dpy[32:0];
            r2_adx  <= m_dx[15:0];
            r2_ady  <= m_dy[15:0];
            r2_sdx  <= r1_dx[16];
            r2_sdy  <= r1_dy[16];
            r2_msum <= r1_msum;
            r2_am   <= r1_am;
            r2_bm   <= r1_bm;
            r2_vel  <= r1_vel;
        end
    end

    // stage 3: distance, dot product, hit test
    logic [32:0]        s_dd;
    logic signed [33:0] s_dot;
    logic signed [33:0] s_mdot;
    logic               s_hit;

    always_comb begin
        s_dd   = {1'b0, r2_sqx} + {1'b0, r2_sqy};
        s_dot  = {r2_dpx[32], r2_dpx} + {r2_dpy[32], r2_dpy};
        s_mdot = s_dot[33] ? -s_dot : s_dot;
        s_hit  = (s_dd < {1'b0, r2_rsq}) && (s_dot[33] || (s_dot == '0));
    end

    logic [32:0]      r3_dd, r3_mdot;
    logic [15:0]      r3_adx, r3_ady;
    logic [16:0]      r3_msum;
    logic [15:0]      r3_am, r3_bm;
    dpc_pkg::t_side   r3_side;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_dd    <= s_dd;
            r3_mdot  <= s_mdot[32:0];
            r3_adx   <= r2_adx;
            r3_ady   <= r2_ady;
            r3_msum  <= r2_msum;
            r3_am    <= r2_am;
            r3_bm    <= r2_bm;
            r3_side.hit <= s_hit;
            r3_side.act <= s_hit && (s_dd != '0) && (r2_msum != '0);
            r3_side.neg[dpc_pkg::LANE_AX] <= s_dot[33] ^ r2_sdx;
            r3_side.neg[dpc_pkg::LANE_AY] <= s_dot[33] ^ r2_sdy;
            r3_side.neg[dpc_pkg::LANE_BX] <= s_dot[33] ^ r2_sdx;
            r3_side.neg[dpc_pkg::LANE_BY] <= s_dot[33] ^ r2_sdy;
            r3_side.vel <= r2_vel;
        end
    end

    // stage 4: mass times component, divisor
    logic [3:0][31:0]          r4_p;
    logic [dpc_pkg::DEN_W-1:0] r4_den;
    logic [32:0]               r4_mdot;
    dpc_pkg::t_side            r4_side;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_p[dpc_pkg::LANE_AX] <= r3_bm * r3_adx;
            r4_p[dpc_pkg::LANE_AY] <= r3_bm * r3_ady;
            r4_p[dpc_pkg::LANE_BX] <= r3_am * r3_adx;
            r4_p[dpc_pkg::LANE_BY] <= r3_am * r3_ady;
            r4_den  <= r3_msum * r3_dd;
            r4_mdot <= r3_mdot;
            r4_side <= r3_side;
        end
    end

    // stage 5: partial products against the two halves of |dv.d|
    logic [3:0][48:0]          r5_lo;
    logic [3:0][47:0]          r5_hi;
    logic [dpc_pkg::DEN_W-1:0] r5_den;
    dpc_pkg::t_side            r5_side;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int l = 0; l < dpc_pkg::LANES; l++) begin
                r5_lo[l] <= r4_p[l] * r4_mdot[16:0];
                r5_hi[l] <= r4_p[l] * r4_mdot[32:17];
            end
            r5_den  <= r4_den;
            r5_side <= r4_side;
        end
    end

    // stage 6: combine partials and double
    logic [3:0][dpc_pkg::NUM_W-1:0] s_num;

    always_comb begin
        for (int l = 0; l < dpc_pkg::LANES; l++) begin
            s_num[l] = (({18'b0, r5_hi[l]} << 17) + {17'b0, r5_lo[l]}) << 1;
        end
    end

    logic [3:0][dpc_pkg::NUM_W-1:0] r6_num;
    logic [dpc_pkg::DEN_W-1:0]      r6_den;
    dpc_pkg::t_side                 r6_side;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_num  <= s_num;
            r6_den  <= r5_den;
            r6_side <= r5_side;
        end
    end

    assign o_num  = r6_num;
    assign o_den  = r6_den;
    assign o_side = r6_side;

endmodule

>>> design/dpc_div.sv
// Restoring divider, one quotient bit per stage, four lanes sharing the divisor.
module dpc_div (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [dpc_pkg::LANES-1:0][dpc_pkg::NUM_W-1:0] i_num,
    input  logic [dpc_pkg::DEN_W-1:0]                     i_den,
    input  dpc_pkg::t_side                                i_side,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [dpc_pkg::LANES-1:0][dpc_pkg::QUO_W-1:0] o_quo,
    output dpc_pkg::t_side                                o_side
);

    localparam int NS = dpc_pkg::DIV_STAGES;
    localparam int QW = dpc_pkg::QUO_W;
    localparam int DW = dpc_pkg::DEN_W;
    localparam int NW = dpc_pkg::NUM_W;

    logic [NS-1:0]                        r_v;
    logic [NS-1:0]                        en;
    logic [dpc_pkg::LANES-1:0][DW-1:0]    r_rem  [NS];
    logic [dpc_pkg::LANES-1:0][QW-1:0]    r_low  [NS];
    logic [DW-1:0]                        r_den  [NS];
    dpc_pkg::t_side                       r_side [NS];

    assign en[NS-1] = !r_v[NS-1] || i_ready;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic                                 p_v;
        logic [dpc_pkg::LANES-1:0][DW-1:0]    p_rem;
        logic [dpc_pkg::LANES-1:0][QW-1:0]    p_low;
        logic [DW-1:0]                        p_den;
        dpc_pkg::t_side                       p_side;
        logic [dpc_pkg::LANES-1:0][DW-1:0]    n_rem;
        logic [dpc_pkg::LANES-1:0][QW-1:0]    n_low;

        if (s == 0) begin : g_head
            always_comb begin
                p_v    = i_valid;
                p_den  = i_den;
                p_side = i_side;
                for (int l = 0; l < dpc_pkg::LANES; l++) begin
                    p_rem[l] = DW'(i_num[l][NW-1:QW]);
                    p_low[l] = i_num[l][QW-1:0];
                end
            end
        end else begin : g_body
            assign p_v    = r_v[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_low  = r_low[s-1];
            assign p_den  = r_den[s-1];
            assign p_side = r_side[s-1];
        end

        if (s < NS - 1) begin : g_en
            assign en[s] = !r_v[s] || en[s+1];
        end

        // shift in the next dividend bit, subtract when it fits
        always_comb begin
            logic [DW:0] t;
            logic        ge;
            for (int l = 0; l < dpc_pkg::LANES; l++) begin
                t        = {p_rem[l], p_low[l][QW-1]};
                ge       = t >= {1'b0, p_den};
                n_rem[l] = ge ? DW'(t - {1'b0, p_den}) : t[DW-1:0];
                n_low[l] = {p_low[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en[s]) begin
                r_v[s] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_rem[s]  <= n_rem;
                r_low[s]  <= n_low;
                r_den[s]  <= p_den;
                r_side[s] <= p_side;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_quo   = r_low[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

>>> design/dpc_out.sv
// Output stage: apply signed impulses, saturate, hold the result word.
module dpc_out (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [dpc_pkg::LANES-1:0][dpc_pkg::QUO_W-1:0] i_quo,
    input  dpc_pkg::t_side                                i_side,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output dpc_pkg::t_out                                 o_data
);

    logic                                r_v;
    dpc_pkg::t_out                       r_data;
    dpc_pkg::t_out                       n_data;
    logic [dpc_pkg::LANES-1:0][15:0]     s_vel;
    logic [dpc_pkg::LANES-1:0]           s_sat;

    assign o_ready = !r_v || i_ready;

    always_comb begin
        logic signed [19:0] q;
        logic signed [20:0] v;
        logic signed [20:0] sum;
        for (int l = 0; l < dpc_pkg::LANES; l++) begin
            q = {1'b0, i_quo[l]};
            if (i_side.neg[l]) q = -q;
            v = {{5{i_side.vel[l][15]}}, i_side.vel[l]};
            if (l == dpc_pkg::LANE_AX || l == dpc_pkg::LANE_AY) begin
                sum = v + {q[19], q};
            end else begin
                sum = v - {q[19], q};
            end
            s_sat[l] = 1'b0;
            if (!i_side.act) begin
                s_vel[l] = i_side.vel[l];
            end else if (sum > dpc_pkg::VEL_MAX) begin
                s_vel[l] = dpc_pkg::VEL_MAX[15:0];
                s_sat[l] = 1'b1;
            end else if (sum < dpc_pkg::VEL_MIN) begin
                s_vel[l] = dpc_pkg::VEL_MIN[15:0];
                s_sat[l] = 1'b1;
            end else begin
                s_vel[l] = sum[15:0];
            end
        end
        n_data.hit           = i_side.hit;
        n_data.new_first_vx  = s_vel[dpc_pkg::LANE_AX];
        n_data.new_first_vy  = s_vel[dpc_pkg::LANE_AY];
        n_data.new_second_vx = s_vel[dpc_pkg::LANE_BX];
        n_data.new_second_vy = s_vel[dpc_pkg::LANE_BY];
        n_data.saturated     = |s_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;

endmodule

>>> design/disc_pair_elastic_collision_unit.sv
// Path: front end, then the 19-stage restoring divider, which sets the depth, then output.
// Throughput: one word per cycle while the output does not stall.
// Every stage has its own valid bit and advances when the next slot is free,
// so bubbles close up and a stalled output does not block the input at once.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
module disc_pair_elastic_collision_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dpc_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output dpc_pkg::t_out  o_data
);

    // front end to divider
    logic                                          fd_valid;
    logic                                          fd_ready;
    logic [dpc_pkg::LANES-1:0][dpc_pkg::NUM_W-1:0] fd_num;
    logic [dpc_pkg::DEN_W-1:0]                     fd_den;
    dpc_pkg::t_side                                fd_side;

    // divider to output stage
    logic                                          do_valid;
    logic                                          do_ready;
    logic [dpc_pkg::LANES-1:0][dpc_pkg::QUO_W-1:0] do_quo;
    dpc_pkg::t_side                                do_side;

    // Compute d, dv, |d|^2, dv.d and the hit test; build the four
    // numerators 2*m*|d component|*|dv.d| and the shared divisor.
    dpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (fd_valid),
        .i_ready (fd_ready),
        .o_num   (fd_num),
        .o_den   (fd_den),
        .o_side  (fd_side)
    );

    // Divide; the quotient magnitude is bounded by twice |dv|, so 19 bits do.
    dpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fd_valid),
        .o_ready (fd_ready),
        .i_num   (fd_num),
        .i_den   (fd_den),
        .i_side  (fd_side),
        .o_valid (do_valid),
        .i_ready (do_ready),
        .o_quo   (do_quo),
        .o_side  (do_side)
    );

    // Apply signs, add or subtract, clamp, and hold the result word.
    dpc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (do_valid),
        .o_ready (do_ready),
        .i_quo   (do_quo),
        .i_side  (do_side),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

>>> design/dpc_checker.sv
// Port-level checks of the collision unit and their binding.
`include "assert_macros.svh"

module dpc_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  dpc_pkg::t_out i_out_data
);

    `DPC_CHECK(a_hold_valid, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped")
    `DPC_CHECK(a_hold_data, i_out_valid && !i_out_ready |=> $stable(i_out_data), "result word changed")
    `DPC_CHECK(a_sat_hit, i_out_valid && !i_out_data.hit |-> !i_out_data.saturated, "saturated without hit")
    `DPC_CHECK_ALWAYS(a_reset, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind disc_pair_elastic_collision_unit dpc_checker u_dpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_data  (o_data)
);

>>> sim/tb_top.sv
// Self-checking testbench of the disc pair elastic collision unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY    = 26;
    localparam int N_RANDOM   = 1330;
    localparam int LONG_HOLD  = 200;

    // Idle phases: percentage of cycles the sender and the receiver sit out.
    typedef enum int {PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} t_phase;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    dpc_pkg::t_in   i_data;
    logic           o_valid;
    logic           i_ready;
    dpc_pkg::t_out  o_data;

    dpc_pkg::t_in   pending_pairs[$];
    dpc_pkg::t_out  expected_velocities[$];
    int     mismatch_count;
    int     words_sent;
    int     words_received;
    int     hits_seen;
    int     sats_seen;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_cycles;
    bit     hold_sender;
    bit     in_taken;

    disc_pair_elastic_collision_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Truncating quotient of magnitudes with the sign rule of the impulse.
    function automatic longint impulse_change(longint m, longint msum, longint dot,
                                              longint dc, longint dd);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        bit           neg;
        longint       mdc;
        longint       mdot;
        neg  = (dot < 0) != (dc < 0);
        mdc  = dc < 0 ? -dc : dc;
        mdot = dot < 0 ? -dot : dot;
        num  = 128'(2 * m * mdc) * 128'(mdot);
        den  = 128'(msum) * 128'(dd);
        quo  = num / den;
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic longint clamp_velocity(longint v, ref bit sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic dpc_pkg::t_out predict_collision(dpc_pkg::t_in p);
        dpc_pkg::t_out r;
        longint dx, dy, dvx, dvy, dd, rs, dot, msum;
        longint nax, nay, nbx, nby;
        bit     hit;
        bit     sat;
        dx   = longint'(p.second_x) - longint'(p.first_x);
        dy   = longint'(p.second_y) - longint'(p.first_y);
        dvx  = longint'(p.second_vx) - longint'(p.first_vx);
        dvy  = longint'(p.second_vy) - longint'(p.first_vy);
        dd   = dx * dx + dy * dy;
        rs   = longint'(p.first_radius) + longint'(p.second_radius);
        dot  = dvx * dx + dvy * dy;
        msum = longint'(p.first_mass) + longint'(p.second_mass);
        hit  = (dd < rs * rs) && (dot <= 0);
        sat  = 1'b0;
        nax  = p.first_vx;
        nay  = p.first_vy;
        nbx  = p.second_vx;
        nby  = p.second_vy;
        if (hit && dd != 0 && msum != 0) begin
            nax = clamp_velocity(nax + impulse_change(p.second_mass, msum, dot, dx, dd), sat);
            nay = clamp_velocity(nay + impulse_change(p.second_mass, msum, dot, dy, dd), sat);
            nbx = clamp_velocity(nbx - impulse_change(p.first_mass, msum, dot, dx, dd), sat);
            nby = clamp_velocity(nby - impulse_change(p.first_mass, msum, dot, dy, dd), sat);
        end
        r.hit           = hit;
        r.new_first_vx  = nax[15:0];
        r.new_first_vy  = nay[15:0];
        r.new_second_vx = nbx[15:0];
        r.new_second_vy = nby[15:0];
        r.saturated     = sat;
        return r;
    endfunction

    // Driver: present the next pair at the falling edge, hold it until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && in_taken) begin
            // word taken at the last rising edge; load the next one or idle
            if (pending_pairs.size() != 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
                i_data  <= pending_pairs.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (pending_pairs.size() != 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
                i_data  <= pending_pairs.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // Receiver ready: random stalls, or a long hold-off counted down here.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance.
    always @(posedge i_clk) begin
        dpc_pkg::t_out exp_word;
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_velocities.push_back(predict_collision(i_data));
                words_sent++;
            end
            if (o_valid && i_ready) begin
                words_received++;
                if (o_data.hit) hits_seen++;
                if (o_data.saturated) sats_seen++;
                if (expected_velocities.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, o_data);
                    mismatch_count++;
                end else begin
                    exp_word = expected_velocities.pop_front();
                    if (o_data.hit !== exp_word.hit) begin
                        $display("%0t: hit expected %0d actual %0d",
                                 $time, exp_word.hit, o_data.hit);
                        mismatch_count++;
                    end
                    if (o_data.new_first_vx !== exp_word.new_first_vx) begin
                        $display("%0t: new_first_vx expected %0d actual %0d",
                                 $time, exp_word.new_first_vx, o_data.new_first_vx);
                        mismatch_count++;
                    end
                    if (o_data.new_first_vy !== exp_word.new_first_vy) begin
                        $display("%0t: new_first_vy expected %0d actual %0d",
                                 $time, exp_word.new_first_vy, o_data.new_first_vy);
                        mismatch_count++;
                    end
                    if (o_data.new_second_vx !== exp_word.new_second_vx) begin
                        $display("%0t: new_second_vx expected %0d actual %0d",
                                 $time, exp_word.new_second_vx, o_data.new_second_vx);
                        mismatch_count++;
                    end
                    if (o_data.new_second_vy !== exp_word.new_second_vy) begin
                        $display("%0t: new_second_vy expected %0d actual %0d",
                                 $time, exp_word.new_second_vy, o_data.new_second_vy);
                        mismatch_count++;
                    end
                    if (o_data.saturated !== exp_word.saturated) begin
                        $display("%0t: saturated expected %0d actual %0d",
                                 $time, exp_word.saturated, o_data.saturated);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    function automatic dpc_pkg::t_in make_pair(int x0, int y0, int vx0, int vy0, int m0,
                                               int r0, int x1, int y1, int vx1, int vy1,
                                               int m1, int r1);
        dpc_pkg::t_in p;
        p.first_x       = x0[15:0];
        p.first_y       = y0[15:0];
        p.first_vx      = vx0[15:0];
        p.first_vy      = vy0[15:0];
        p.first_mass    = m0[15:0];
        p.first_radius  = r0[14:0];
        p.second_x      = x1[15:0];
        p.second_y      = y1[15:0];
        p.second_vx     = vx1[15:0];
        p.second_vy     = vy1[15:0];
        p.second_mass   = m1[15:0];
        p.second_radius = r1[14:0];
        return p;
    endfunction

    // Random pair; most are near-contact pairs so hits are common.
    function automatic dpc_pkg::t_in random_pair();
        dpc_pkg::t_in p;
        int  sel;
        int  span;
        p   = dpc_pkg::t_in'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        sel = $urandom_range(99);
        if (p.first_mass == 0) p.first_mass = 16'd1;
        if (p.second_mass == 0) p.second_mass = 16'd1;
        if (sel < 70) begin
            // close pair: offset and radii drawn from the same span, random velocities
            span = (sel < 20) ? 32 : (sel < 50) ? 2000 : 30000;
            p.second_x = p.first_x + 16'($urandom_range(2 * span) - span);
            p.second_y = p.first_y + 16'($urandom_range(2 * span) - span);
            p.first_radius  = 15'($urandom_range(span + 1));
            p.second_radius = 15'($urandom_range(span + 1));
            if (sel < 10) begin
                p.first_mass  = 16'($urandom_range(1, 4));
                p.second_mass = 16'($urandom_range(60000, 65535));
            end
            if ($urandom_range(3) == 0) begin
                p.first_vx  = 16'($signed(16'($urandom)) >>> $urandom_range(8));
                p.second_vx = 16'($signed(16'($urandom)) >>> $urandom_range(8));
            end
        end
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || i_valid || expected_velocities.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_phase ph;
        int     n;
        pending_pairs.delete();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_data         = '0;
        mismatch_count = 0;
        words_sent     = 0;
        words_received = 0;
        hits_seen      = 0;
        sats_seen      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        hold_sender    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, head-on hits, saturation, coincident centres,
        // touching but not overlapping, separating pairs, lopsided masses.
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 256, 32, 32, 0, -256, 0, 256, 32));
        pending_pairs.push_back(make_pair(0, 0, -256, 0, 256, 32, 32, 0, 256, 0, 256, 32));
        pending_pairs.push_back(make_pair(0, 0, 32767, 32767, 65535, 32767,
                                          1, 1, -32768, -32768, 65535, 32767));
        pending_pairs.push_back(make_pair(0, 0, 32767, 0, 1, 100, 10, 0, -32768, 0, 65535, 100));
        pending_pairs.push_back(make_pair(5, 5, 100, -100, 300, 10, 5, 5, -100, 100, 300, 10));
        pending_pairs.push_back(make_pair(5, 5, 0, 0, 300, 0, 5, 5, 0, 0, 300, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 256, 16, 32, 0, -10, 0, 256, 16));
        pending_pairs.push_back(make_pair(-32768, -32768, 1, 1, 1, 0,
                                          32767, 32767, -1, -1, 1, 0));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767, 65535, 32767,
                                          32767, 32767, -32768, -32768, 65535, 32767));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 256, 20, 3, 4, 0, 0, 256, 20));
        pending_pairs.push_back(make_pair(0, 0, 500, 300, 65535, 50, 30, 20, -700, 0, 1, 50));
        pending_pairs.push_back(make_pair(0, 0, -32768, 0, 1, 20, -1, 0, 32767, 0, 1, 20));
        pending_pairs.push_back(make_pair(100, -200, -3000, 4000, 999, 300,
                                          -50, 80, 2000, -1000, 2, 300));
        pending_pairs.push_back(make_pair(0, 0, 0, 32767, 1, 8, 0, -1, 0, -32768, 65535, 8));
        wait_drained();

        // Random part in idle phases; a long receiver hold in the first phase.
        for (int k = 0; k < 4; k++) begin
            ph = t_phase'(k);
            case (ph)
                PH_NONE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                PH_SEND_IDLE:  begin send_idle_pct = 76; recv_stall_pct = 0;  end
                PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default:       begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            n = N_RANDOM / 4;
            for (int j = 0; j < n; j++) pending_pairs.push_back(random_pair());
            if (ph == PH_NONE) begin
                // stop the receiver while the sender keeps offering words
                @(negedge i_clk);
                hold_cycles = LONG_HOLD;
            end
            if (ph == PH_SEND_IDLE) begin
                // pause the sender until the pipeline is empty
                while (pending_pairs.size() > n / 2) @(posedge i_clk);
                hold_sender = 1'b1;
                while (i_valid || expected_velocities.size() != 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Covered %0d pairs in, %0d results out, %0d hits, %0d saturated,",
                 words_sent, words_received, hits_seen, sats_seen);
        $display("across four idle phases with a long output hold and a sender pause.");
        if (mismatch_count == 0 && expected_velocities.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard time limit well beyond the slowest legal run.
    initial begin
        #4000000;
        $display("timeout after %0d results", words_received);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
